/* hdl/tccc_pkg.sv */
package tccc_pkg;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] ENTER_RESET = 8'd13;
  localparam logic [7:0] BACKSPACE_RESET = 8'd8;

  localparam logic REG_ENTER = 1'b0;
  localparam logic REG_BACKSPACE = 1'b1;

  localparam logic KIND_CELL = 1'b0;
  localparam logic KIND_ROW_CLEAR = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [4:0] mem_row;
    logic [6:0] column;
    logic [7:0] cell_data;
    logic [4:0] scroll_now;
    logic       last;
  } result_t;

  // Results produced by one character: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

/* hdl/text_console_cursor_controller_core.sv */
// Channel | Handshake             | Payload
// input   | in_valid / in_ready   | char_code
// output  | out_valid / out_ready | kind, mem_row, column, cell_data, scroll_now, last
// config  | cfg_wen               | cfg_addr, cfg_wdata
//
// A character is taken at the edge where in_valid and in_ready are both high, and its
// results (none, one or two) enter a four-entry result queue at that same edge; the
// first is offered on the output once any older results have left the queue.
// The queue drains one result per cycle while out_ready is high.
// in_ready is high while the queue holds at most two results; a low out_ready holds the queue, which can drop in_ready.
// rst (synchronous) clears the cursor, scroll offset and queue, and returns the
// enter and backspace codes to 13 and 8.
module text_console_cursor_controller_core #(
  parameter int COLS = 80,
  parameter int LINES = 30,
  parameter int MEM_ROWS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [4:0] mem_row,
  output logic [6:0] column,
  output logic [7:0] cell_data,
  output logic [4:0] scroll_now,
  output logic       last,
  input  logic       cfg_wen,
  input  logic       cfg_addr,
  input  logic [7:0] cfg_wdata
);

  logic [7:0] enter_code, backspace_code;
  logic accept;
  tccc_pkg::push_t push;
  tccc_pkg::result_t head_r;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enter_code     <= tccc_pkg::ENTER_RESET;
      backspace_code <= tccc_pkg::BACKSPACE_RESET;
    end else if (cfg_wen) begin
      case (cfg_addr)
        tccc_pkg::REG_ENTER:     enter_code <= cfg_wdata;
        tccc_pkg::REG_BACKSPACE: backspace_code <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tccc_step #(
    .COLS(COLS),
    .LINES(LINES),
    .MEM_ROWS(MEM_ROWS)
  ) u_step (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .char_code(char_code),
    .enter_code(enter_code),
    .backspace_code(backspace_code),
    .push(push)
  );

  tccc_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push_en(accept),
    .push(push),
    .room(in_ready),
    .pop_valid(out_valid),
    .pop_ready(out_ready),
    .pop_data(head_r)
  );

  assign kind       = head_r.kind;
  assign mem_row    = head_r.mem_row;
  assign column     = head_r.column;
  assign cell_data  = head_r.cell_data;
  assign scroll_now = head_r.scroll_now;
  assign last       = head_r.last;

endmodule

/* hdl/tccc_step.sv */
module tccc_step #(
  parameter int COLS = 80,
  parameter int LINES = 30,
  parameter int MEM_ROWS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          char_code,
  input  logic [7:0]          enter_code,
  input  logic [7:0]          backspace_code,
  output tccc_pkg::push_t     push
);

  localparam int COL_W = $clog2(COLS);
  localparam int LINE_W = $clog2(LINES);
  localparam int ROW_W = $clog2(MEM_ROWS);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);
  localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(LINES - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MEM_ROWS - 1);

  logic [COL_W-1:0]  cursor_col, cursor_col_next;
  logic [LINE_W-1:0] cursor_line, cursor_line_next;
  logic [ROW_W-1:0]  scroll_offset, scroll_offset_next;
  // Physical row of the cursor line, kept as (scroll + line) mod MEM_ROWS
  logic [ROW_W-1:0]  cursor_row, cursor_row_next;

  logic [ROW_W-1:0] row_inc, row_dec, scroll_inc;
  logic is_line_end, is_backspace, at_origin, col_wrap, line_wrap;
  tccc_pkg::result_t cell_r, clear_r, back_r;

  always_comb begin
    row_inc    = (cursor_row == ROW_LAST) ? '0 : cursor_row + ROW_W'(1);
    row_dec    = (cursor_row == '0) ? ROW_LAST : cursor_row - ROW_W'(1);
    scroll_inc = (scroll_offset == ROW_LAST) ? '0 : scroll_offset + ROW_W'(1);

    is_line_end  = (char_code == tccc_pkg::NEWLINE_CODE) || (char_code == enter_code);
    is_backspace = (char_code == backspace_code);
    at_origin    = (cursor_line == '0) && (cursor_col == '0);
    col_wrap     = (cursor_col == COL_LAST);
    line_wrap    = (cursor_line == LINE_LAST);

    cell_r.kind       = tccc_pkg::KIND_CELL;
    cell_r.mem_row    = 5'(cursor_row);
    cell_r.column     = 7'(cursor_col);
    cell_r.cell_data  = is_line_end ? 8'd0 : (is_backspace ? 8'd0 : char_code);
    cell_r.scroll_now = 5'(scroll_offset);
    cell_r.last       = 1'b1;

    // After a scroll the last line lands one physical row further down
    clear_r.kind       = tccc_pkg::KIND_ROW_CLEAR;
    clear_r.mem_row    = 5'(row_inc);
    clear_r.column     = 7'd0;
    clear_r.cell_data  = 8'd0;
    clear_r.scroll_now = 5'(scroll_inc);
    clear_r.last       = 1'b1;

    back_r.kind       = tccc_pkg::KIND_CELL;
    back_r.mem_row    = (cursor_col == '0) ? 5'(row_dec) : 5'(cursor_row);
    back_r.column     = (cursor_col == '0) ? 7'(COL_LAST) : 7'(cursor_col - COL_W'(1));
    back_r.cell_data  = 8'd0;
    back_r.scroll_now = 5'(scroll_offset);
    back_r.last       = 1'b1;

    cursor_col_next    = cursor_col;
    cursor_line_next   = cursor_line;
    scroll_offset_next = scroll_offset;
    cursor_row_next    = cursor_row;
    push.count  = 2'd0;
    push.first  = cell_r;
    push.second = clear_r;

    if (is_line_end || (!is_backspace && col_wrap)) begin
      push.count = 2'd1;
      cursor_col_next = '0;
      cursor_row_next = row_inc;
      if (line_wrap) begin
        push.count = 2'd2;
        push.first.last = 1'b0;
        scroll_offset_next = scroll_inc;
      end else begin
        cursor_line_next = cursor_line + LINE_W'(1);
      end
    end else if (is_backspace) begin
      if (!at_origin) begin
        push.count = 2'd2;
        push.first.last = 1'b0;
        push.second = back_r;
        if (cursor_col == '0) begin
          cursor_col_next  = COL_LAST;
          cursor_line_next = cursor_line - LINE_W'(1);
          cursor_row_next  = row_dec;
        end else begin
          cursor_col_next = cursor_col - COL_W'(1);
        end
      end
    end else begin
      push.count = 2'd1;
      cursor_col_next = cursor_col + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col    <= '0;
      cursor_line   <= '0;
      scroll_offset <= '0;
      cursor_row    <= '0;
    end else if (accept) begin
      cursor_col    <= cursor_col_next;
      cursor_line   <= cursor_line_next;
      scroll_offset <= scroll_offset_next;
      cursor_row    <= cursor_row_next;
    end
  end

endmodule

/* hdl/tccc_queue.sv */
module tccc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_en,
  input  tccc_pkg::push_t     push,
  output logic                room,
  output logic                pop_valid,
  input  logic                pop_ready,
  output tccc_pkg::result_t   pop_data
);

  tccc_pkg::result_t slots [4];
  logic [1:0] head, tail;
  logic [2:0] count, count_next;
  logic [1:0] push_n;
  logic       pop;

  always_comb begin
    push_n     = push_en ? push.count : 2'd0;
    pop        = pop_valid && pop_ready;
    count_next = count + 3'(push_n) - 3'(pop);
    room       = (count <= 3'd2);
    pop_valid  = (count != 3'd0);
    pop_data   = slots[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + 2'(pop);
      tail  <= tail + push_n;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      slots[tail] <= push.first;
    end
    if (push_n == 2'd2) begin
      slots[tail + 2'd1] <= push.second;
    end
  end

endmodule

/* test/text_console_cursor_controller_core_tb.sv */
`timescale 1ns / 100ps

module text_console_cursor_controller_core_tb;

  localparam int COLS = 80;
  localparam int LINES = 30;
  localparam int MEM_ROWS = 32;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] char_code = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       kind;
  logic [4:0] mem_row;
  logic [6:0] column;
  logic [7:0] cell_data;
  logic [4:0] scroll_now;
  logic       last;
  logic       cfg_wen = 1'b0;
  logic       cfg_addr = tccc_pkg::REG_ENTER;
  logic [7:0] cfg_wdata = 8'd0;

  text_console_cursor_controller_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .char_code(char_code),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .mem_row(mem_row),
    .column(column),
    .cell_data(cell_data),
    .scroll_now(scroll_now),
    .last(last),
    .cfg_wen(cfg_wen),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Predictor state: cursor, scroll and the two code registers.
  int         cur_line = 0;
  int         cur_col = 0;
  int         scroll_pos = 0;
  logic [7:0] enter_val = tccc_pkg::ENTER_RESET;
  logic [7:0] bksp_val = tccc_pkg::BACKSPACE_RESET;

  logic [7:0]        char_backlog[$];
  tccc_pkg::result_t expected_writes[$];
  int                send_idle = 34;
  int                recv_idle = 45;
  logic              in_taken = 1'b0;
  int                mismatches = 0;
  int                stall_count = 0;

  function automatic tccc_pkg::result_t mk_write(logic k, int line, int col,
                                                 logic [7:0] data, logic fin);
    tccc_pkg::result_t r;
    r.kind = k;
    r.mem_row = 5'((scroll_pos + line) % MEM_ROWS);
    r.column = 7'(col);
    r.cell_data = data;
    r.scroll_now = 5'(scroll_pos);
    r.last = fin;
    return r;
  endfunction

  // Queue the head write, then move to the next line and scroll if it runs off the end.
  task automatic push_and_newline(input tccc_pkg::result_t head);
    cur_col = 0;
    if (cur_line + 1 >= LINES) begin
      cur_line = LINES - 1;
      scroll_pos = (scroll_pos + 1) % MEM_ROWS;
      head.last = 1'b0;
      expected_writes.push_back(head);
      expected_writes.push_back(mk_write(tccc_pkg::KIND_ROW_CLEAR, LINES - 1, 0, 8'd0, 1'b1));
    end else begin
      cur_line++;
      expected_writes.push_back(head);
    end
  endtask

  task automatic predict_console_writes(input logic [7:0] ch);
    if (ch == tccc_pkg::NEWLINE_CODE || ch == enter_val) begin
      push_and_newline(mk_write(tccc_pkg::KIND_CELL, cur_line, cur_col, 8'd0, 1'b1));
    end else if (ch == bksp_val) begin
      if (cur_line != 0 || cur_col != 0) begin
        expected_writes.push_back(mk_write(tccc_pkg::KIND_CELL, cur_line, cur_col, 8'd0, 1'b0));
        if (cur_col == 0) begin
          cur_line--;
          cur_col = COLS - 1;
        end else begin
          cur_col--;
        end
        expected_writes.push_back(mk_write(tccc_pkg::KIND_CELL, cur_line, cur_col, 8'd0, 1'b1));
      end
    end else if (cur_col + 1 >= COLS) begin
      push_and_newline(mk_write(tccc_pkg::KIND_CELL, cur_line, cur_col, ch, 1'b1));
    end else begin
      expected_writes.push_back(mk_write(tccc_pkg::KIND_CELL, cur_line, cur_col, ch, 1'b1));
      cur_col++;
    end
  endtask

  // Driver: inputs change on the falling edge.
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_taken) begin
        if (char_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          in_valid <= 1'b1;
          char_code <= char_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Monitor: sample both channels on the rising edge.
  always @(posedge clk) begin
    tccc_pkg::result_t seen;
    tccc_pkg::result_t want;
    if (rst) begin
      in_taken <= 1'b0;
      stall_count <= 0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready)
        predict_console_writes(char_code);
      if (out_valid && out_ready) begin
        seen.kind = kind;
        seen.mem_row = mem_row;
        seen.column = column;
        seen.cell_data = cell_data;
        seen.scroll_now = scroll_now;
        seen.last = last;
        if (expected_writes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"unexpected transaction: kind %0d row %0d col %0d data %0d",
                      " scroll %0d last %0d"},
                     kind, mem_row, column, cell_data, scroll_now, last);
        end else begin
          want = expected_writes.pop_front();
          if (seen.kind !== want.kind || seen.mem_row !== want.mem_row ||
              seen.column !== want.column || seen.cell_data !== want.cell_data ||
              seen.scroll_now !== want.scroll_now || seen.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch exp: kind %0d row %0d col %0d data %0d scroll %0d last %0d",
                       want.kind, want.mem_row, want.column, want.cell_data,
                       want.scroll_now, want.last);
              $display("         got: kind %0d row %0d col %0d data %0d scroll %0d last %0d",
                       seen.kind, seen.mem_row, seen.column, seen.cell_data,
                       seen.scroll_now, seen.last);
            end
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        stall_count <= 0;
      else
        stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("text_console_cursor_controller_core verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic addr, input logic [7:0] val);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wen <= 1'b0;
    if (addr == tccc_pkg::REG_ENTER)
      enter_val = val;
    else
      bksp_val = val;
  endtask

  // Hold off until the block has drained, then let it settle.
  task automatic wait_drained();
    while (char_backlog.size() > 0 || in_valid || expected_writes.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly text lines with line ends, some backspace bursts, some raw bytes.
  task automatic queue_random_chars(input int n_items);
    int count;
    int sel;
    int len;
    count = 0;
    while (count < n_items) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(70, 170) : $urandom_range(0, 12);
        repeat (len) char_backlog.push_back(8'($urandom_range(32, 126)));
        char_backlog.push_back($urandom_range(0, 1) ? tccc_pkg::NEWLINE_CODE : enter_val);
        count += len + 1;
      end else if (sel < 8) begin
        len = $urandom_range(1, 20);
        repeat (len) char_backlog.push_back(bksp_val);
        count += len;
      end else begin
        char_backlog.push_back(8'($urandom_range(0, 255)));
        count++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: backspace at origin, byte extremes, line ends, backspace across a line.
    char_backlog = '{tccc_pkg::BACKSPACE_RESET, 8'd0, 8'd255, 8'd65, tccc_pkg::NEWLINE_CODE,
                     tccc_pkg::BACKSPACE_RESET, tccc_pkg::ENTER_RESET, 8'd128, 8'd127,
                     tccc_pkg::BACKSPACE_RESET, tccc_pkg::BACKSPACE_RESET, 8'd1,
                     tccc_pkg::NEWLINE_CODE, tccc_pkg::BACKSPACE_RESET,
                     tccc_pkg::BACKSPACE_RESET, tccc_pkg::BACKSPACE_RESET,
                     tccc_pkg::ENTER_RESET, tccc_pkg::NEWLINE_CODE, 8'd170, 8'd85};
    wait_drained();
    queue_random_chars(160);
    wait_drained();

    write_reg(tccc_pkg::REG_ENTER, 8'd0);
    write_reg(tccc_pkg::REG_BACKSPACE, 8'd255);
    queue_random_chars(160);
    wait_drained();

    send_idle = 45;
    recv_idle = 34;
    write_reg(tccc_pkg::REG_ENTER, 8'd255);
    write_reg(tccc_pkg::REG_BACKSPACE, 8'd0);
    queue_random_chars(160);
    wait_drained();

    // Backspace code collides with newline: line end wins.
    write_reg(tccc_pkg::REG_ENTER, tccc_pkg::ENTER_RESET);
    write_reg(tccc_pkg::REG_BACKSPACE, tccc_pkg::NEWLINE_CODE);
    queue_random_chars(160);
    wait_drained();

    // Backspace code collides with enter: line end wins.
    send_idle = 0;
    recv_idle = 0;
    write_reg(tccc_pkg::REG_ENTER, 8'd127);
    write_reg(tccc_pkg::REG_BACKSPACE, 8'd127);
    queue_random_chars(80);
    wait_drained();
    write_reg(tccc_pkg::REG_BACKSPACE, tccc_pkg::BACKSPACE_RESET);
    queue_random_chars(80);
    wait_drained();

    if (mismatches == 0 && expected_writes.size() == 0)
      $display("text_console_cursor_controller_core verification clean");
    else
      $display("text_console_cursor_controller_core verification failed");
    $finish;
  end

endmodule
